FILE: hdl/lpwm_pkg.sv
// Shared types and constants of the LED PWM mode controller.
package lpwm_pkg;

   localparam int CMD_W      = 3;
   localparam int LEVEL_W    = 8;
   localparam int CMP_W      = 9;
   localparam int MODE_W     = 3;
   localparam int PCT_W      = 7;
   localparam int TICK_W     = 8;
   localparam int CFG_W      = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int POS_MAX_W  = 4;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_BRIGHT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ON           = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OFF          = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BREATHE_ON   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BREATHE_OFF  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FLASH_ON     = 3'd6;
   localparam logic [CMD_W-1:0] CMD_FLASH_OFF    = 3'd7;

   // mode codes as reported on the result channel
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FLASH_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLASH_PATTERN  = 1'd1;

   localparam logic [CMP_W-1:0]   COMPARE_DARK   = 9'd500;
   localparam logic [CMP_W-1:0]   COMPARE_FULL   = 9'd0;
   localparam logic [CMP_W-1:0]   RAMP_STEP      = 9'd5;
   localparam logic [TICK_W-1:0]  BREATHE_TICKS  = 8'd20;
   localparam logic [TICK_W-1:0]  TICK_MAX       = 8'd255;
   localparam logic [LEVEL_W-1:0] BRIGHT_MAX     = 8'd100;
   localparam logic [CFG_W-1:0]   INTERVAL_RESET = 8'd200;
   localparam logic [CFG_W-1:0]   PATTERN_RESET  = 8'd85;

   typedef struct packed {
      logic [CFG_W-1:0] flash_interval_ms;
      logic [CFG_W-1:0] flash_pattern;
   } cfg_type;

   typedef struct packed {
      logic [CMP_W-1:0]  pwm_compare;
      logic [MODE_W-1:0] mode_now;
   } result_type;

endpackage

FILE: hdl/lpwm_core.sv
// Mode state registers and next-state logic of the LED PWM mode controller.
module lpwm_core #(
   parameter int PATTERN_LEN = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_accept,
   input  logic [lpwm_pkg::CMD_W-1:0]    in_command,
   input  logic [lpwm_pkg::LEVEL_W-1:0]  in_level_request,
   input  lpwm_pkg::cfg_type             cfg,
   output lpwm_pkg::result_type          result
);
   import lpwm_pkg::*;

   localparam int POS_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(PATTERN_LEN - 1);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [MODE_W-1:0] saved_mode_ff, saved_mode_in;
   logic [PCT_W-1:0]  bright_ff, bright_in;
   logic [PCT_W-1:0]  saved_bright_ff, saved_bright_in;
   logic [CMP_W-1:0]  ramp_ff, ramp_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CMP_W-1:0]  compare_ff, compare_in;

   logic              breathing;
   logic [TICK_W-1:0] tick_count;
   logic [CMP_W:0]    ramp_sum;
   logic [LEVEL_W-1:0] level_clamped;

   // 500 - 5*pct, pct never above 100
   function automatic logic [CMP_W-1:0] level_cmp(input logic [PCT_W-1:0] pct);
      logic [CMP_W:0] times5;
      times5 = {1'b0, pct, 2'b00} + {3'b000, pct};
      return CMP_W'({1'b0, COMPARE_DARK} - times5);
   endfunction

   // positions past bit 7 read dark
   function automatic logic [CMP_W-1:0] pattern_cmp(input logic [CFG_W-1:0] pat,
                                                    input logic [POS_W-1:0] pos);
      logic [POS_MAX_W-1:0] pos_wide;
      pos_wide = POS_MAX_W'(pos);
      if (pos_wide < POS_MAX_W'(CFG_W) && pat[pos_wide[2:0]])
         return COMPARE_FULL;
      return COMPARE_DARK;
   endfunction

   assign breathing     = (mode_ff == MODE_UP) || (mode_ff == MODE_DOWN);
   assign tick_count    = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 8'd1;
   assign ramp_sum      = {1'b0, ramp_ff} + {1'b0, RAMP_STEP};
   assign level_clamped = (in_level_request > BRIGHT_MAX) ? BRIGHT_MAX : in_level_request;

   always_comb begin
      mode_in         = mode_ff;
      saved_mode_in   = saved_mode_ff;
      bright_in       = bright_ff;
      saved_bright_in = saved_bright_ff;
      ramp_in         = ramp_ff;
      elapsed_in      = elapsed_ff;
      pos_in          = pos_ff;
      compare_in      = compare_ff;
      case (in_command)
         CMD_TICK: begin
            if (breathing) begin
               elapsed_in = tick_count;
               if (tick_count >= BREATHE_TICKS) begin
                  elapsed_in = '0;
                  if (mode_ff == MODE_DOWN) begin
                     if (ramp_ff != '0)
                        ramp_in = (ramp_ff >= RAMP_STEP) ? ramp_ff - RAMP_STEP : '0;
                     else
                        mode_in = MODE_UP;
                  end else begin
                     if (ramp_ff < COMPARE_DARK)
                        ramp_in = (ramp_sum > {1'b0, COMPARE_DARK}) ? COMPARE_DARK
                                                                     : ramp_sum[CMP_W-1:0];
                     else
                        mode_in = MODE_DOWN;
                  end
                  compare_in = ramp_in;
               end
            end else if (mode_ff == MODE_FLASH) begin
               elapsed_in = tick_count;
               if (tick_count >= cfg.flash_interval_ms) begin
                  elapsed_in = '0;
                  pos_in     = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
                  compare_in = pattern_cmp(cfg.flash_pattern, pos_in);
               end
            end
         end
         CMD_SET_BRIGHT: begin
            bright_in = level_clamped[PCT_W-1:0];
            if (mode_ff == MODE_ON)
               compare_in = level_cmp(bright_in);
         end
         CMD_ON: begin
            if (mode_ff == MODE_OFF) begin
               mode_in    = MODE_ON;
               compare_in = level_cmp(bright_ff);
            end
         end
         CMD_OFF: begin
            mode_in    = MODE_OFF;
            compare_in = COMPARE_DARK;
         end
         CMD_BREATHE_ON: begin
            if (!breathing) begin
               saved_bright_in = bright_ff;
               saved_mode_in   = mode_ff;
            end
            mode_in    = MODE_DOWN;
            ramp_in    = COMPARE_DARK;
            elapsed_in = '0;
         end
         CMD_BREATHE_OFF, CMD_FLASH_OFF: begin
            if ((in_command == CMD_BREATHE_OFF && breathing) ||
                (in_command == CMD_FLASH_OFF && mode_ff == MODE_FLASH)) begin
               bright_in = saved_bright_ff;
               if (saved_mode_ff == MODE_ON) begin
                  mode_in    = MODE_ON;
                  compare_in = level_cmp(saved_bright_ff);
               end else begin
                  mode_in    = MODE_OFF;
                  compare_in = COMPARE_DARK;
               end
            end
         end
         CMD_FLASH_ON: begin
            if (mode_ff != MODE_FLASH) begin
               saved_bright_in = bright_ff;
               saved_mode_in   = mode_ff;
            end
            pos_in     = '0;
            elapsed_in = '0;
            compare_in = pattern_cmp(cfg.flash_pattern, '0);
            mode_in    = MODE_FLASH;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_OFF;
         saved_mode_ff   <= MODE_OFF;
         bright_ff       <= '0;
         saved_bright_ff <= '0;
         ramp_ff         <= COMPARE_DARK;
         elapsed_ff      <= '0;
         pos_ff          <= '0;
         compare_ff      <= COMPARE_DARK;
      end else if (in_accept) begin
         mode_ff         <= mode_in;
         saved_mode_ff   <= saved_mode_in;
         bright_ff       <= bright_in;
         saved_bright_ff <= saved_bright_in;
         ramp_ff         <= ramp_in;
         elapsed_ff      <= elapsed_in;
         pos_ff          <= pos_in;
         compare_ff      <= compare_in;
      end
   end

   assign result.pwm_compare = compare_in;
   assign result.mode_now    = mode_in;

endmodule

FILE: hdl/led_pwm_mode_controller.sv
// Top level of the LED PWM mode controller: handshake, skid stage and registers.
// Each accepted request's result is registered in the result register or the skid entry.
// Throughput: one transaction per cycle while req_stall is low; the mode state updates
//   in a single pass of next-state logic, and a two-entry output (result register plus
//   skid) accepts one more request while the result side stalls.
// Reset (synchronous, active high): mode off, compare 500, interval 200, pattern 85,
//   no result pending.
module led_pwm_mode_controller #(
   parameter int PATTERN_LEN = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lpwm_pkg::CMD_W-1:0]      req_command,
   input  logic [lpwm_pkg::LEVEL_W-1:0]    req_level_request,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lpwm_pkg::CMP_W-1:0]      rsp_pwm_compare,
   output logic [lpwm_pkg::MODE_W-1:0]     rsp_mode_now,
   // register write port
   input  logic                            csr_we,
   input  logic [lpwm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [lpwm_pkg::CFG_W-1:0]      csr_wdata
);
   import lpwm_pkg::*;

   cfg_type    cfg_ff;
   result_type next_result;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       req_accept;
   logic       rsp_take;

   // The skid entry is only filled when the result register is held, so the
   // request side stalls purely on a registered flag.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_interval_ms <= INTERVAL_RESET;
         cfg_ff.flash_pattern     <= PATTERN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLASH_INTERVAL: cfg_ff.flash_interval_ms <= csr_wdata;
            CSR_FLASH_PATTERN:  cfg_ff.flash_pattern     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // mode state and its next value for the request being accepted
   lpwm_core #(
      .PATTERN_LEN(PATTERN_LEN)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (req_accept),
      .in_command       (req_command),
      .in_level_request (req_level_request),
      .cfg              (cfg_ff),
      .result           (next_result)
   );

   // result register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (!out_valid_ff || rsp_take)
               out_valid_ff <= 1'b1;
            else
               skid_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take)
            out_ff <= skid_ff;
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take)
            out_ff <= next_result;
         else
            skid_ff <= next_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pwm_compare = out_ff.pwm_compare;
   assign rsp_mode_now    = out_ff.mode_now;

   // a skid entry only exists behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without a result in the output register");

   // a transaction accepted against a stalled result must land in the skid entry
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("transaction accepted under stall was not captured");

   // off mode always drives the lamp dark
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode_now == MODE_OFF) |-> (rsp_pwm_compare == COMPARE_DARK))
      else $error("off mode with a compare value other than dark");

   // a taken result with no skid and no new transaction leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !skid_valid_ff && !req_accept) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule
